@@ src/sha224_pkg.sv @@
// Shared types, constants and round functions for the SHA-224 hash block.
`timescale 1ns / 1ps
package sha224_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned DigWords = 7;
    localparam int unsigned QueueDepth = 4;

    typedef logic [WordW-1:0] t_word;

    // byte-queue entry between the front and the compression core
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_item;

    localparam t_word InitChain [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

@@ src/sha224_hash.sv @@
// Top level of the SHA-224 hash block: byte queue in front of the compression core.
//
// Usage: push one message byte per transfer on i_data_byte with i_byte_valid and
// i_last; the item is taken when push is high and full is low. An empty message
// is a single item with i_byte_valid low and i_last high.
// Results: seven digest words H0..H6 appear on o_digest_word with o_word_index;
// o_last_word marks H6. A word is taken when pop is high and empty is low.
// Flow: the core takes bytes while in its input state; every 64th byte starts a block
// of 64 rounds plus one final add in the single round unit, during which the core
// takes no bytes. The four-entry byte queue keeps taking bytes while a block
// compresses, until it is full.
// After the last item, padding costs one or two blocks before empty goes low. If
// the receiver stalls, the digest waits and no further bytes are consumed by the
// core until all seven words transfer.
// Reset (synchronous, i_rst_n low) empties the queue, loads the initial chain
// values and clears the length count.
`timescale 1ns / 1ps
module sha224_hash #(
    parameter int unsigned QUEUE_DEPTH = sha224_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha224_pkg::*;

    t_item in_item, q_item;
    logic  q_avail, q_take;

    assign in_item = '{data_byte: i_data_byte, byte_valid: i_byte_valid, last: i_last};

    sha224_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_item(in_item),
        .o_avail(q_avail), .i_take(q_take), .o_item(q_item)
    );

    sha224_core u_core (
        .i_clk, .i_rst_n, .i_avail(q_avail), .o_take(q_take), .i_item(q_item),
        .o_empty(empty), .pop, .o_digest_word, .o_word_index, .o_last_word
    );
endmodule

@@ src/sha224_front.sv @@
// Input byte queue: takes items from the source and holds them for the core.
`timescale 1ns / 1ps
module sha224_front #(
    parameter int unsigned DEPTH = sha224_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  sha224_pkg::t_item   i_item,
    output logic                o_avail,
    input  logic                i_take,
    output sha224_pkg::t_item   o_item
);
    import sha224_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item             r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [AW:0]       r_cnt;
    logic              wr_en, rd_en;

    assign full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_avail;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("byte queue count overflow");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !rd_en |=> full) else $error("queue full dropped without read");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && !rd_en |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not advance");
`endif
endmodule

@@ src/sha224_core.sv @@
// Compression core: packs bytes, pads, runs 64 rounds per block, emits digest.
`timescale 1ns / 1ps
module sha224_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    output logic                o_take,
    input  sha224_pkg::t_item   i_item,
    output logic                o_empty,
    input  logic                pop,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    import sha224_pkg::*;

    typedef enum logic [5:0] {
        S_IN    = 6'b000001,
        S_ROUND = 6'b000010,
        S_ADD   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state       r_state;
    t_word        r_w [16];       // message schedule window
    t_word        r_h [8];
    t_word        r_v [8];
    logic [63:0]  r_cnt;
    logic [5:0]   r_rnd;
    logic         r_fin;          // last item of the message has been taken
    logic         r_two;          // another length block follows
    logic [2:0]   r_oi;
    // set once the padding block has been built for this message
    logic         r_done_q;

    t_word t1, t2, wnew;
    logic [5:0] pos;

    assign pos  = r_cnt[5:0];
    assign o_take = (r_state == S_IN);

    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + RoundK[r_rnd] + r_w[0];
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign wnew = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];

    assign o_empty       = (r_state != S_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'(DigWords-1));

    // put one byte at pos, optionally zeroing the block's words after its word
    function automatic void put_byte(inout t_word w [16], input logic [5:0] p,
                                     input logic [7:0] b, input logic zero_rest);
        logic [3:0] wi;
        wi = p[5:2];
        case (p[1:0])
            2'd0:    w[wi] = {b, 24'h0};
            2'd1:    w[wi][23:16] = b;
            2'd2:    w[wi][15:8]  = b;
            default: w[wi][7:0]   = b;
        endcase
        if (zero_rest) begin
            for (int k = 0; k < 16; k++) begin
                if (4'(k) > wi) w[k] = '0;
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        t_word tw [16];
        tw = r_w;
        if (!i_rst_n) begin
            r_state  <= S_IN;
            r_cnt    <= '0;
            r_rnd    <= '0;
            r_fin    <= 1'b0;
            r_two    <= 1'b0;
            r_oi     <= '0;
            r_done_q <= 1'b0;
            for (int k = 0; k < 8; k++) r_h[k] <= InitChain[k];
        end else begin
            unique case (r_state)
                S_IN: begin
                    if (i_avail) begin
                        if (i_item.byte_valid) begin
                            put_byte(tw, pos, i_item.data_byte, 1'b0);
                            r_cnt <= r_cnt + 64'd1;
                        end
                        r_w <= tw;
                        r_fin <= i_item.last;
                        r_two <= 1'b0;
                        if (i_item.byte_valid && pos == 6'd63) begin
                            r_state <= S_ROUND;
                            for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                            r_rnd <= '0;
                        end else if (i_item.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                    r_w[15] <= wnew;
                    r_v[0] <= t1 + t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                    if (r_two)      r_state <= S_LEN;
                    else if (r_fin) r_state <= r_done_q ? S_OUT : S_PAD;
                    else            r_state <= S_IN;
                end
                S_PAD: begin
                    put_byte(tw, pos, 8'h80, 1'b1);
                    if (pos >= 6'd56) begin
                        r_w <= tw;
                        r_two <= 1'b1;
                    end else begin
                        tw[14] = r_cnt[60:29];
                        tw[15] = {r_cnt[28:0], 3'b000};
                        r_w <= tw;
                        r_two <= 1'b0;
                    end
                    r_done_q <= 1'b1;
                    for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                    r_rnd <= '0;
                    r_state <= S_ROUND;
                end
                S_LEN: begin
                    for (int k = 0; k < 14; k++) r_w[k] <= '0;
                    r_w[14] <= r_cnt[60:29];
                    r_w[15] <= {r_cnt[28:0], 3'b000};
                    r_two <= 1'b0;
                    for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                    r_rnd <= '0;
                    r_state <= S_ROUND;
                end
                S_OUT: begin
                    if (pop) begin
                        if (r_oi == 3'(DigWords-1)) begin
                            r_oi <= '0;
                            r_cnt <= '0;
                            r_fin <= 1'b0;
                            r_done_q <= 1'b0;
                            for (int k = 0; k < 8; k++) r_h[k] <= InitChain[k];
                            r_state <= S_IN;
                        end else begin
                            r_oi <= r_oi + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

`ifndef SYNTH
    a_oi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oi <= 3'(DigWords-1)) else $error("digest index out of range");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND && r_rnd == 6'd63 |=> r_state == S_ADD)
        else $error("round counter did not end block");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !pop |=> r_state == S_OUT && $stable(r_oi))
        else $error("digest word lost while stalled");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IN |-> !o_take) else $error("byte taken while busy");
`endif
endmodule
